// ===== rtl/regular_grid_trace_index_macros.svh =====
// Assertion macros shared by the trace index block.
// Each macro expects clk to be visible where it is used; the first two also use rst_n.
`ifndef REGULAR_GRID_TRACE_INDEX_MACROS_SVH
`define REGULAR_GRID_TRACE_INDEX_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define RGTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is applied.
`define RGTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset itself.
`define RGTI_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rgti_pkg.sv =====
// Shared types and constants of the regular grid trace index block.
// No dependencies; every module of the block imports this package.
package rgti_pkg;

  localparam int TRACE_W    = 64;
  localparam int OUT_LINE_W = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int TDATA_W    = TRACE_W + 2 * OUT_LINE_W;
  localparam int INLINE_LSB = TRACE_W;
  localparam int CROSS_LSB  = TRACE_W + OUT_LINE_W;

  // Conversion direction carried in tuser of the input channel.
  localparam logic KIND_TO_LINES = 1'b0;
  localparam logic KIND_TO_TRACE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_INLINE    = 2'd0,
    CFG_LAST_INLINE     = 2'd1,
    CFG_FIRST_CROSSLINE = 2'd2,
    CFG_LAST_CROSSLINE  = 2'd3
  } cfg_idx_t;

  // Control that travels with each item through the pipeline.
  typedef struct packed {
    logic valid;
    logic kind;
    logic ok;
  } ctl_t;

  // One finished result: tuser holds valid_res.
  typedef struct packed {
    logic [TDATA_W-1:0] tdata;
    logic               tuser;
  } res_t;

endpackage

// ===== rtl/regular_grid_trace_index.sv =====
// Regular grid trace index: converts between trace numbers and line pairs.
// Depends on rgti_pkg, rgti_front, rgti_div_step, rgti_finish, rgti_skid
// and the assertion macros header.
//
// Usage:
//   The configuration port sets the first and last inline and crossline of
//   the grid; write it only while no item is in flight. Only the low
//   LINE_BITS bits of each register and line number are used.
//   in_tuser selects the conversion: 0 turns the trace number into an
//   inline and crossline, 1 turns the line pair into a row-major trace number.
//   Every input item gives exactly one result item. out_tuser is valid_res;
//   when it is 0 the operand lies outside the grid and out_tdata is zero.
// Pipeline:
//   One item is accepted in every cycle while in_tready is high. An item
//   passes through four front stages, one stage for each of the 64 quotient
//   bits of the trace division, a final check stage and the output register.
// Reset and stall:
//   Reset clears every valid bit in the pipeline and sets all four grid
//   registers to 0. When the receiver stalls, results wait in the output
//   register and one skid entry; once that entry fills, in_tready drops and
//   the whole pipeline holds until the receiver takes a result.
`include "regular_grid_trace_index_macros.svh"

module regular_grid_trace_index #(
  parameter int LINE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel. tdata: trace_number, inline_number, crossline_number.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rgti_pkg::TDATA_W-1:0]   in_tdata,
  // tuser: kind.
  input  logic                           in_tuser,
  // Result channel. tdata: trace_out, inline_out, crossline_out.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rgti_pkg::TDATA_W-1:0]   out_tdata,
  // tuser: valid_res.
  output logic                           out_tuser,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [rgti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgti_pkg::CFG_W-1:0]     cfg_wdata
);
  import rgti_pkg::*;

  localparam int DIV_STEPS = TRACE_W;

  logic [LINE_BITS-1:0] first_il_r, last_il_r, first_xl_r, last_xl_r;
  logic [LINE_BITS-1:0] wm1_r, lim_il_r;
  logic [LINE_BITS:0]   w_r;
  logic                 empty_r;

  logic                 en;
  logic                 in_acc;
  ctl_t                 div_ctl  [DIV_STEPS+1];
  logic [TRACE_W-1:0]   div_work [DIV_STEPS+1];
  logic [LINE_BITS-1:0] div_rem  [DIV_STEPS+1];
  logic                 fin_valid;
  res_t                 fin_res, out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_il_r <= '0;
      last_il_r  <= '0;
      first_xl_r <= '0;
      last_xl_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FIRST_INLINE:    first_il_r <= cfg_wdata[LINE_BITS-1:0];
        CFG_LAST_INLINE:     last_il_r  <= cfg_wdata[LINE_BITS-1:0];
        CFG_FIRST_CROSSLINE: first_xl_r <= cfg_wdata[LINE_BITS-1:0];
        CFG_LAST_CROSSLINE:  last_xl_r  <= cfg_wdata[LINE_BITS-1:0];
      endcase
    end
  end

  // Grid spans are kept in registers so the divider stages see a flop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r    <= '0;
      w_r      <= (LINE_BITS+1)'(1);
      lim_il_r <= '0;
      empty_r  <= 1'b0;
    end else begin
      wm1_r    <= last_xl_r - first_xl_r;
      w_r      <= {1'b0, last_xl_r - first_xl_r} + (LINE_BITS+1)'(1);
      lim_il_r <= last_il_r - first_il_r;
      empty_r  <= (first_il_r > last_il_r) || (first_xl_r > last_xl_r);
    end
  end

  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  rgti_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_acc),
    .in_kind  (in_tuser),
    .in_trace (in_tdata[TRACE_W-1:0]),
    .in_il    (in_tdata[INLINE_LSB +: LINE_BITS]),
    .in_xl    (in_tdata[CROSS_LSB +: LINE_BITS]),
    .first_il (first_il_r),
    .last_il  (last_il_r),
    .first_xl (first_xl_r),
    .last_xl  (last_xl_r),
    .wm1      (wm1_r),
    .empty    (empty_r),
    .ctl_o    (div_ctl[0]),
    .work_o   (div_work[0])
  );

  assign div_rem[0] = '0;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rgti_div_step #(.LINE_BITS(LINE_BITS)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .w      (w_r),
      .ctl_i  (div_ctl[g]),
      .work_i (div_work[g]),
      .rem_i  (div_rem[g]),
      .ctl_o  (div_ctl[g+1]),
      .work_o (div_work[g+1]),
      .rem_o  (div_rem[g+1])
    );
  end

  rgti_finish #(.LINE_BITS(LINE_BITS)) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_i    (div_ctl[DIV_STEPS]),
    .work_i   (div_work[DIV_STEPS]),
    .rem_i    (div_rem[DIV_STEPS]),
    .first_il (first_il_r),
    .first_xl (first_xl_r),
    .lim_il   (lim_il_r),
    .valid_o  (fin_valid),
    .res_o    (fin_res)
  );

  rgti_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (fin_valid),
    .up_data   (fin_res),
    .ready_o   (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res.tdata;
  assign out_tuser = out_res.tuser;

  `RGTI_ASSERT_RST(a_reset_clears, !rst_n, !out_tvalid && in_tready, "reset left items in flight")
  `RGTI_ASSERT_IMP(a_stall_has_result, !in_tready, out_tvalid, "input stalled with no result waiting")
  `RGTI_ASSERT_NXT(a_skid_drains, !in_tready && out_tready, in_tready, "skid entry did not drain")
  `RGTI_ASSERT_IMP(a_invalid_zero, out_tvalid && !out_tuser, out_tdata == '0, "invalid result not zero")

endmodule

// ===== rtl/rgti_front.sv =====
// Front stages: input capture, range checks and the line pair to trace product.
// Depends on rgti_pkg.
module rgti_front #(
  parameter int LINE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_kind,
  input  logic [rgti_pkg::TRACE_W-1:0] in_trace,
  input  logic [LINE_BITS-1:0]         in_il,
  input  logic [LINE_BITS-1:0]         in_xl,
  input  logic [LINE_BITS-1:0]         first_il,
  input  logic [LINE_BITS-1:0]         last_il,
  input  logic [LINE_BITS-1:0]         first_xl,
  input  logic [LINE_BITS-1:0]         last_xl,
  input  logic [LINE_BITS-1:0]         wm1,
  input  logic                         empty,
  output rgti_pkg::ctl_t               ctl_o,
  output logic [rgti_pkg::TRACE_W-1:0] work_o
);
  import rgti_pkg::*;

  localparam int PROD_W = 2 * LINE_BITS;

  ctl_t                 a_ctl_r, a_ctl_nxt;
  logic [TRACE_W-1:0]   a_trace_r;
  logic [LINE_BITS-1:0] a_il_r, a_xl_r;

  ctl_t                 b_ctl_r, b_ctl_nxt;
  logic [TRACE_W-1:0]   b_trace_r;
  logic [LINE_BITS-1:0] b_di_r, b_dx_r;
  logic                 in_rng;

  ctl_t                 c_ctl_r;
  logic [TRACE_W-1:0]   c_trace_r;
  logic [PROD_W-1:0]    c_prod_r, c_prod_nxt;
  logic [LINE_BITS:0]   c_sum_r, c_sum_nxt;

  ctl_t                 d_ctl_r;
  logic [TRACE_W-1:0]   d_work_r, d_work_nxt;

  always_comb begin
    a_ctl_nxt.valid = in_valid;
    a_ctl_nxt.kind  = in_kind;
    a_ctl_nxt.ok    = 1'b0;
  end

  assign in_rng = (a_il_r >= first_il) && (a_il_r <= last_il) &&
                  (a_xl_r >= first_xl) && (a_xl_r <= last_xl);

  always_comb begin
    b_ctl_nxt.valid = a_ctl_r.valid;
    b_ctl_nxt.kind  = a_ctl_r.kind;
    b_ctl_nxt.ok    = !empty && ((a_ctl_r.kind == KIND_TO_LINES) || in_rng);
  end

  // The grid width is wm1 + 1, so the product splits into d_i * wm1 + d_i.
  assign c_prod_nxt = b_di_r * wm1;
  assign c_sum_nxt  = {1'b0, b_di_r} + {1'b0, b_dx_r};

  always_comb begin
    if (c_ctl_r.kind == KIND_TO_TRACE) begin
      d_work_nxt = TRACE_W'(c_prod_r + PROD_W'(c_sum_r));
    end else begin
      d_work_nxt = c_trace_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
      d_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= b_ctl_nxt;
      c_ctl_r <= b_ctl_r;
      d_ctl_r <= c_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_trace_r <= in_trace;
      a_il_r    <= in_il;
      a_xl_r    <= in_xl;
      b_trace_r <= a_trace_r;
      b_di_r    <= a_il_r - first_il;
      b_dx_r    <= a_xl_r - first_xl;
      c_trace_r <= b_trace_r;
      c_prod_r  <= c_prod_nxt;
      c_sum_r   <= c_sum_nxt;
      d_work_r  <= d_work_nxt;
    end
  end

  assign ctl_o  = d_ctl_r;
  assign work_o = d_work_r;

endmodule

// ===== rtl/rgti_div_step.sv =====
// One restoring division step: produces one quotient bit per stage.
// Depends on rgti_pkg. Items converting line pairs pass through unchanged.
module rgti_div_step #(
  parameter int LINE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [LINE_BITS:0]           w,
  input  rgti_pkg::ctl_t               ctl_i,
  input  logic [rgti_pkg::TRACE_W-1:0] work_i,
  input  logic [LINE_BITS-1:0]         rem_i,
  output rgti_pkg::ctl_t               ctl_o,
  output logic [rgti_pkg::TRACE_W-1:0] work_o,
  output logic [LINE_BITS-1:0]         rem_o
);
  import rgti_pkg::*;

  ctl_t                 ctl_r;
  logic [TRACE_W-1:0]   work_r, work_nxt;
  logic [LINE_BITS-1:0] rem_r, rem_nxt;
  logic [LINE_BITS:0]   sh, diff;
  logic                 ge;

  // The work word shifts dividend bits out at the top and quotient bits in
  // at the bottom. The remainder stays below w, so one subtract suffices.
  assign sh   = {rem_i, work_i[TRACE_W-1]};
  assign ge   = (sh >= w);
  assign diff = sh - w;

  always_comb begin
    if (ctl_i.kind == KIND_TO_LINES) begin
      work_nxt = {work_i[TRACE_W-2:0], ge};
      rem_nxt  = ge ? diff[LINE_BITS-1:0] : sh[LINE_BITS-1:0];
    end else begin
      work_nxt = work_i;
      rem_nxt  = rem_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign work_o = work_r;
  assign rem_o  = rem_r;

endmodule

// ===== rtl/rgti_finish.sv =====
// Final stage: inline count check, line offsets and result formatting.
// Depends on rgti_pkg.
module rgti_finish #(
  parameter int LINE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  rgti_pkg::ctl_t               ctl_i,
  input  logic [rgti_pkg::TRACE_W-1:0] work_i,
  input  logic [LINE_BITS-1:0]         rem_i,
  input  logic [LINE_BITS-1:0]         first_il,
  input  logic [LINE_BITS-1:0]         first_xl,
  input  logic [LINE_BITS-1:0]         lim_il,
  output logic                         valid_o,
  output rgti_pkg::res_t               res_o
);
  import rgti_pkg::*;

  logic                 valid_r;
  res_t                 res_r, res_nxt;
  logic                 q_fits;
  logic [LINE_BITS-1:0] il_sum, xl_sum;

  // For trace items the work word holds the quotient by the grid width.
  assign q_fits = (work_i[TRACE_W-1:LINE_BITS] == '0) &&
                  (work_i[LINE_BITS-1:0] <= lim_il);
  assign il_sum = first_il + work_i[LINE_BITS-1:0];
  assign xl_sum = first_xl + rem_i;

  always_comb begin
    res_nxt = '0;
    if (ctl_i.kind == KIND_TO_LINES) begin
      if (ctl_i.ok && q_fits) begin
        res_nxt.tuser = 1'b1;
        res_nxt.tdata[INLINE_LSB +: OUT_LINE_W] = OUT_LINE_W'(il_sum);
        res_nxt.tdata[CROSS_LSB +: OUT_LINE_W]  = OUT_LINE_W'(xl_sum);
      end
    end else begin
      if (ctl_i.ok) begin
        res_nxt.tuser = 1'b1;
        res_nxt.tdata[TRACE_W-1:0] = work_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = valid_r;
  assign res_o   = res_r;

endmodule

// ===== rtl/rgti_skid.sv =====
// Output register with one skid entry between the pipeline and the receiver.
// Depends on rgti_pkg.
module rgti_skid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  rgti_pkg::res_t up_data,
  output logic           ready_o,
  output logic           out_valid,
  input  logic           out_ready,
  output rgti_pkg::res_t out_data
);
  import rgti_pkg::*;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;

  // The pipeline advances only while the skid entry is free, so ready is
  // a register and never depends on the receiver in the same cycle.
  assign ready_o = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (up_valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (up_valid) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= up_data;
      end else begin
        skid_data_r <= up_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
